### rtl/hrcv_pkg.sv
// ----------------------------------------------------------------------------
// hrcv_pkg
// Shared constants, types and conversion tables of the HSV region colour vote.
// ----------------------------------------------------------------------------
package hrcv_pkg;

    localparam int COUNT_BITS  = 16;
    localparam int MAX_REGIONS = 4;
    localparam int RED_W       = COUNT_BITS + 1;
    localparam int VOTE_W      = 3;
    localparam int VOTE_CAP    = (MAX_REGIONS < 7) ? MAX_REGIONS : 7;
    localparam int MIN_VOTES   = 2;
    localparam int TALLY_W     = 17;
    localparam int TALLY_MAX   = 131071;
    localparam int BOX_W       = 48;
    localparam int MINCNT_W    = 16;
    localparam int STAB_W      = 20;
    localparam int HTAB_W      = 17;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0]
    {
        CLS_NONE  = 2'd0,
        CLS_GREEN = 2'd1,
        CLS_BLUE  = 2'd2,
        CLS_RED   = 2'd3
    } class_t;

    // Kind of a result beat.
    typedef enum logic
    {
        KIND_REGION = 1'b0,
        KIND_TAG    = 1'b1
    } kind_t;

    // Register indexes; each register sits at byte address 8 * index.
    typedef enum logic [2:0]
    {
        REG_GREEN  = 3'd0,
        REG_BLUE   = 3'd1,
        REG_RED_LO = 3'd2,
        REG_RED_HI = 3'd3,
        REG_MINCNT = 3'd4
    } reg_idx_t;

    // One classified pixel item as it waits between the two halves.
    typedef struct packed
    {
        logic       green_hit;
        logic       blue_hit;
        logic [1:0] red_add;
        logic       region_end;
        logic       tag_end;
    } item_t;

    typedef logic [STAB_W-1:0] stab_tab_t [0:255];
    typedef logic [HTAB_W-1:0] htab_tab_t [0:255];

    // Quotient rounded half to even, by restoring long division.
    function automatic logic [31:0] div_rne(input logic [31:0] num, input logic [31:0] den);
        logic [31:0] q;
        logic [32:0] r;
        q = '0;
        r = '0;
        for (int i = 31; i >= 0; i--)
        begin
            r = {r[31:0], num[i]};
            if (r >= {1'b0, den})
            begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        if ({r[31:0], 1'b0} > {1'b0, den} || ({r[31:0], 1'b0} == {1'b0, den} && q[0]))
        begin
            q = q + 32'd1;
        end
        return q;
    endfunction

    function automatic stab_tab_t make_stab();
        stab_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = (i == 0) ? '0 : STAB_W'(div_rne(32'd255 << 12, 32'(i)));
        end
        return t;
    endfunction

    function automatic htab_tab_t make_htab();
        htab_tab_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = (i == 0) ? '0 : HTAB_W'(div_rne(32'd180 << 12, 32'(6 * i)));
        end
        return t;
    endfunction

    localparam stab_tab_t SAT_TAB = make_stab();
    localparam htab_tab_t HUE_TAB = make_htab();

    // Inclusive test of one HSV box; lo above hi matches nothing.
    function automatic logic in_box(input logic [BOX_W-1:0] box, input logic [7:0] h,
                                    input logic [7:0] s, input logic [7:0] v);
        logic ok;
        ok = (h >= box[7:0])   && (h <= box[15:8]) &&
             (s >= box[23:16]) && (s <= box[31:24]) &&
             (v >= box[39:32]) && (v <= box[47:40]);
        return ok;
    endfunction

endpackage

### rtl/hsv_region_colour_vote_unit.sv
// ----------------------------------------------------------------------------
// hsv_region_colour_vote_unit
// Colour vote over the sampling regions around a tag, from BGR pixel beats.
// ----------------------------------------------------------------------------
// The block takes one pixel beat per clock while s_axis_tready is high. Each
// pixel passes through a two-stage HSV converter (table lookup, then the
// saturation and hue multiplications) and a box test. The classified pixels
// wait in a four-entry queue in front of the counting half; the input stays
// ready while the queue and the two converter stages together hold fewer
// than four items. A beat that ends both a region and a tag stays at the head
// of the queue until both of its result beats, region then tag, have been
// issued; every other beat yields at most one. The result register lets a
// new pixel be accepted while a finished result still waits to be taken.
// Configuration registers sit at byte addresses 0, 8, 16, 24 and 32 and are
// only to be written while the block is idle.
// ----------------------------------------------------------------------------
module hsv_region_colour_vote_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // pix_blue[7:0], pix_green[15:8], pix_red[23:16]
    input  logic        s_axis_tlast,   // region_end
    input  logic [1:0]  s_axis_tuser,   // pixel_present[0], tag_end[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // damage_class[1:0], tally[18:2], zero fill above
    output logic        m_axis_tlast,   // last
    output logic        m_axis_tuser,   // result_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import hrcv_pkg::*;

    logic [BOX_W-1:0]    green_range_reg, blue_range_reg, red_lo_reg, red_hi_reg;
    logic [MINCNT_W-1:0] min_count_reg;
    logic                wr_en;
    logic [2:0]          reg_idx;

    logic                push, pop, not_empty;
    item_t               push_item, head;
    logic [QCNT_W-1:0]   q_count;

    // Registers are decoded on bits 5:3 of the address, one per 8 bytes.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_range_reg <= '0;
            blue_range_reg  <= '0;
            red_lo_reg      <= '0;
            red_hi_reg      <= '0;
            min_count_reg   <= MINCNT_W'(1);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_GREEN:  green_range_reg <= pwdata[BOX_W-1:0];
                REG_BLUE:   blue_range_reg  <= pwdata[BOX_W-1:0];
                REG_RED_LO: red_lo_reg      <= pwdata[BOX_W-1:0];
                REG_RED_HI: red_hi_reg      <= pwdata[BOX_W-1:0];
                REG_MINCNT: min_count_reg   <= pwdata[MINCNT_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_GREEN:  prdata = {16'b0, green_range_reg};
            REG_BLUE:   prdata = {16'b0, blue_range_reg};
            REG_RED_LO: prdata = {16'b0, red_lo_reg};
            REG_RED_HI: prdata = {16'b0, red_hi_reg};
            REG_MINCNT: prdata = {48'b0, min_count_reg};
            default:    prdata = '0;
        endcase
    end

    hrcv_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .green_range   (green_range_reg),
        .blue_range    (blue_range_reg),
        .red_lo_range  (red_lo_reg),
        .red_hi_range  (red_hi_reg),
        .q_count       (q_count),
        .push          (push),
        .push_item     (push_item)
    );

    hrcv_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .not_empty (not_empty),
        .count     (q_count)
    );

    hrcv_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .not_empty       (not_empty),
        .pop             (pop),
        .min_pixel_count (min_count_reg),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tuser    (m_axis_tuser)
    );

endmodule

### rtl/hrcv_fifo.sv
// ----------------------------------------------------------------------------
// hrcv_fifo
// Short queue of classified items between the front and the back half.
// ----------------------------------------------------------------------------
module hrcv_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  hrcv_pkg::item_t         push_item,
    input  logic                    pop,
    output hrcv_pkg::item_t         head,
    output logic                    not_empty,
    output logic [hrcv_pkg::QCNT_W-1:0] count
);
    import hrcv_pkg::*;

    item_t               mem_reg [0:QDEPTH-1];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    assign head      = mem_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

### rtl/hrcv_front.sv
// ----------------------------------------------------------------------------
// hrcv_front
// Accepts pixel beats, converts BGR to HSV over two stages and tests the boxes.
// ----------------------------------------------------------------------------
module hrcv_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [23:0]                  s_axis_tdata,
    input  logic                         s_axis_tlast,
    input  logic [1:0]                   s_axis_tuser,
    input  logic [hrcv_pkg::BOX_W-1:0]   green_range,
    input  logic [hrcv_pkg::BOX_W-1:0]   blue_range,
    input  logic [hrcv_pkg::BOX_W-1:0]   red_lo_range,
    input  logic [hrcv_pkg::BOX_W-1:0]   red_hi_range,
    input  logic [hrcv_pkg::QCNT_W-1:0]  q_count,
    output logic                         push,
    output hrcv_pkg::item_t              push_item
);
    import hrcv_pkg::*;

    logic [7:0]  b, g, r, vmax, vmin, diff;
    logic signed [11:0] hnum;
    logic [QCNT_W-1:0]  occupancy;
    logic        accept;

    logic               p1_valid_reg, p2_valid_reg;
    logic [7:0]         p1_v_reg, p1_diff_reg;
    logic [STAB_W-1:0]  p1_stab_reg;
    logic [HTAB_W-1:0]  p1_htab_reg;
    logic signed [11:0] p1_hnum_reg;
    logic [2:0]         p1_flags_reg;
    logic [7:0]         p2_h_reg, p2_s_reg, p2_v_reg;
    logic [2:0]         p2_flags_reg;

    logic [27:0]        sprod;
    logic [28:0]        ssum;
    logic signed [29:0] hprod;
    logic signed [30:0] hsum;
    logic signed [18:0] hq, hq_adj;
    logic               pres;

    assign b = s_axis_tdata[7:0];
    assign g = s_axis_tdata[15:8];
    assign r = s_axis_tdata[23:16];

    // Credit check: every item in flight has a queue slot kept for it.
    assign occupancy     = q_count + QCNT_W'(p1_valid_reg) + QCNT_W'(p2_valid_reg);
    assign s_axis_tready = (occupancy < QCNT_W'(QDEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        vmax = b;
        vmin = b;
        if (g > vmax) vmax = g;
        if (r > vmax) vmax = r;
        if (g < vmin) vmin = g;
        if (r < vmin) vmin = r;
        diff = vmax - vmin;
        if (vmax == r)
            hnum = $signed({4'b0, g}) - $signed({4'b0, b});
        else if (vmax == g)
            hnum = $signed({4'b0, b}) - $signed({4'b0, r}) + $signed({3'b0, diff, 1'b0});
        else
            hnum = $signed({4'b0, r}) - $signed({4'b0, g}) + $signed({2'b0, diff, 2'b0});
    end

    always_ff @(posedge clk)
    begin
        p1_v_reg     <= vmax;
        p1_diff_reg  <= diff;
        p1_stab_reg  <= SAT_TAB[vmax];
        p1_htab_reg  <= HUE_TAB[diff];
        p1_hnum_reg  <= hnum;
        p1_flags_reg <= {s_axis_tuser[1], s_axis_tlast, s_axis_tuser[0]};
    end

    always_comb
    begin
        sprod  = {20'b0, p1_diff_reg} * {8'b0, p1_stab_reg};
        ssum   = {1'b0, sprod} + 29'd2048;
        hprod  = 30'(p1_hnum_reg * $signed({1'b0, p1_htab_reg}));
        hsum   = $signed({hprod[29], hprod}) + 31'sd2048;
        hq     = hsum[30:12];
        hq_adj = hq[18] ? (hq + 19'sd180) : hq;
    end

    always_ff @(posedge clk)
    begin
        p2_h_reg     <= hq_adj[7:0];
        p2_s_reg     <= ssum[19:12];
        p2_v_reg     <= p1_v_reg;
        p2_flags_reg <= p1_flags_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // Flags: bit 0 pixel present, bit 1 region end, bit 2 tag end.
    assign pres = p2_flags_reg[0];

    always_comb
    begin
        push_item.green_hit  = pres && in_box(green_range, p2_h_reg, p2_s_reg, p2_v_reg);
        push_item.blue_hit   = pres && in_box(blue_range, p2_h_reg, p2_s_reg, p2_v_reg);
        push_item.red_add    = 2'(pres && in_box(red_lo_range, p2_h_reg, p2_s_reg, p2_v_reg))
                             + 2'(pres && in_box(red_hi_range, p2_h_reg, p2_s_reg, p2_v_reg));
        push_item.region_end = p2_flags_reg[1];
        push_item.tag_end    = p2_flags_reg[2];
    end

    assign push = p2_valid_reg;

endmodule

### rtl/hrcv_back.sv
// ----------------------------------------------------------------------------
// hrcv_back
// Counts classified pixels, decides region classes and tag verdicts, and
// holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module hrcv_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  hrcv_pkg::item_t                 head,
    input  logic                            not_empty,
    output logic                            pop,
    input  logic [hrcv_pkg::MINCNT_W-1:0]   min_pixel_count,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,
    output logic                            m_axis_tlast,
    output logic                            m_axis_tuser
);
    import hrcv_pkg::*;

    typedef enum logic [1:0]
    {
        PH_FIRST = 2'b01,
        PH_TAG   = 2'b10
    } phase_t;

    phase_t              phase_reg;
    logic [COUNT_BITS-1:0] green_reg, blue_reg, green_eff, blue_eff;
    logic [RED_W-1:0]    red_reg, red_eff, rbest;
    logic [RED_W:0]      red_sum;
    logic [VOTE_W-1:0]   mould_reg, water_reg, blood_reg, vbest;
    class_t              rcls, vcls;
    logic [RED_W-1:0]    minc;
    logic                step, both_ends, res_fire;
    logic [TALLY_W-1:0]  rtally;

    logic                out_valid_reg, out_kind_reg, out_last_reg;
    class_t              out_cls_reg;
    logic [TALLY_W-1:0]  out_tally_reg;

    assign step      = not_empty && (!out_valid_reg || m_axis_tready);
    assign both_ends = head.region_end && head.tag_end;
    assign pop       = step && !(phase_reg == PH_FIRST && both_ends);
    assign minc      = RED_W'(min_pixel_count);
    assign res_fire  = step && (head.region_end || head.tag_end || phase_reg == PH_TAG);

    always_comb
    begin
        green_eff = (head.green_hit && green_reg != '1) ? green_reg + COUNT_BITS'(1) : green_reg;
        blue_eff  = (head.blue_hit && blue_reg != '1) ? blue_reg + COUNT_BITS'(1) : blue_reg;
        red_sum   = {1'b0, red_reg} + (RED_W + 1)'(head.red_add);
        red_eff   = red_sum[RED_W] ? '1 : red_sum[RED_W-1:0];

        rbest = '0;
        rcls  = CLS_NONE;
        if ({1'b0, green_eff} > rbest && {1'b0, green_eff} >= minc)
        begin
            rbest = {1'b0, green_eff};
            rcls  = CLS_GREEN;
        end
        if ({1'b0, blue_eff} > rbest && {1'b0, blue_eff} >= minc)
        begin
            rbest = {1'b0, blue_eff};
            rcls  = CLS_BLUE;
        end
        if (red_eff > rbest && red_eff >= minc)
        begin
            rbest = red_eff;
            rcls  = CLS_RED;
        end
        rtally = (32'(rbest) > 32'(TALLY_MAX)) ? TALLY_W'(TALLY_MAX) : TALLY_W'(rbest);

        vbest = '0;
        vcls  = CLS_NONE;
        if (mould_reg > vbest)
        begin
            vbest = mould_reg;
            vcls  = CLS_GREEN;
        end
        if (water_reg > vbest)
        begin
            vbest = water_reg;
            vcls  = CLS_BLUE;
        end
        if (blood_reg > vbest)
        begin
            vbest = blood_reg;
            vcls  = CLS_RED;
        end
        if (vbest < VOTE_W'(MIN_VOTES))
        begin
            vbest = '0;
            vcls  = CLS_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            if (phase_reg == PH_FIRST && head.region_end)
            begin
                out_kind_reg  <= KIND_REGION;
                out_cls_reg   <= rcls;
                out_tally_reg <= rtally;
                out_last_reg  <= !head.tag_end;
            end
            else
            begin
                out_kind_reg  <= KIND_TAG;
                out_cls_reg   <= vcls;
                out_tally_reg <= TALLY_W'(vbest);
                out_last_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            out_valid_reg <= 1'b0;
            green_reg     <= '0;
            blue_reg      <= '0;
            red_reg       <= '0;
            mould_reg     <= '0;
            water_reg     <= '0;
            blood_reg     <= '0;
        end
        else
        begin
            if (res_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (step)
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        if (head.region_end)
                        begin
                            green_reg     <= '0;
                            blue_reg      <= '0;
                            red_reg       <= '0;
                            if (rcls == CLS_GREEN && mould_reg != VOTE_W'(VOTE_CAP))
                                mould_reg <= mould_reg + VOTE_W'(1);
                            if (rcls == CLS_BLUE && water_reg != VOTE_W'(VOTE_CAP))
                                water_reg <= water_reg + VOTE_W'(1);
                            if (rcls == CLS_RED && blood_reg != VOTE_W'(VOTE_CAP))
                                blood_reg <= blood_reg + VOTE_W'(1);
                            if (head.tag_end)
                                phase_reg <= PH_TAG;
                        end
                        else if (head.tag_end)
                        begin
                            green_reg     <= '0;
                            blue_reg      <= '0;
                            red_reg       <= '0;
                            mould_reg     <= '0;
                            water_reg     <= '0;
                            blood_reg     <= '0;
                        end
                        else
                        begin
                            green_reg <= green_eff;
                            blue_reg  <= blue_eff;
                            red_reg   <= red_eff;
                        end
                    end
                    PH_TAG:
                    begin
                        green_reg     <= '0;
                        blue_reg      <= '0;
                        red_reg       <= '0;
                        mould_reg     <= '0;
                        water_reg     <= '0;
                        blood_reg     <= '0;
                        phase_reg     <= PH_FIRST;
                    end
                    default:
                    begin
                        phase_reg <= PH_FIRST;
                    end
                endcase
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_tally_reg, out_cls_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_kind_reg;

endmodule
